FILE: rtl/core/swrr_pkg.sv
// Package: shared types and codes for the receive reorder block.
`timescale 1ns / 1ps
`default_nettype none
package swrr_pkg;

  localparam int DEF_REORDER_SLOTS = 8;
  localparam int DEF_HEADER_BYTES  = 20;
  localparam logic [15:0] WINDOW_RESET = 16'd1440;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOS  = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
  } entry_t;

  // Control from the sequencer to the row of cells
  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } chain_ctrl_t;

  // Status from the row of cells back to the sequencer
  typedef struct packed {
    entry_t head;
    logic   dup;
  } chain_stat_t;

  typedef struct packed {
    logic        action;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] segment_length;
    logic [15:0] received_length;
    logic        ack_flag;
    logic        fin_flag;
    logic        checksum_ok;
    logic [15:0] buffer_space;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] deliver_seq;
    logic [15:0] deliver_length;
    logic [31:0] ack_value;
    logic [15:0] advertised_window;
    logic        last;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/swrr_cell.sv
// One reorder table slot: holds an entry, inserts or shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module swrr_cell (
  input  wire                        clk,
  input  wire swrr_pkg::chain_ctrl_t ctrl,
  input  wire                        valid_i,
  input  wire swrr_pkg::entry_t      left_entry,
  input  wire swrr_pkg::entry_t      right_entry,
  input  wire                        left_lt,
  output swrr_pkg::entry_t           entry_o,
  output logic                       lt_o,
  output logic                       eq_o
);
  import swrr_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Compare stored seq against the incoming one
  assign lt_o    = valid_i && (entry_r.seq < ctrl.new_entry.seq);
  assign eq_o    = valid_i && (entry_r.seq == ctrl.new_entry.seq);
  assign entry_o = entry_r;

  // Pick next content: hold, open a gap, or move toward the head
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (!left_lt) begin
          entry_nxt = left_entry;
        end else if (!lt_o) begin
          entry_nxt = ctrl.new_entry;
        end
      end
      OP_SHIFT: entry_nxt = right_entry;
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/swrr_chain.sv
// Row of reorder cells kept sorted by sequence number.
`timescale 1ns / 1ps
`default_nettype none
module swrr_chain #(
  parameter int SLOTS = swrr_pkg::DEF_REORDER_SLOTS,
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  wire                        clk,
  input  wire swrr_pkg::chain_ctrl_t ctrl,
  input  wire [CW-1:0]               count,
  output swrr_pkg::chain_stat_t      stat
);
  import swrr_pkg::*;

  entry_t           ent [SLOTS];
  logic [SLOTS-1:0] lt;
  logic [SLOTS-1:0] eq;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_l;
      if (g == 0) begin : g_first
        assign left_e = ctrl.new_entry;
        assign left_l = 1'b1;
      end else begin : g_mid
        assign left_e = ent[g-1];
        assign left_l = lt[g-1];
      end
      if (g == SLOTS - 1) begin : g_last
        assign right_e = ent[g];
      end else begin : g_inner
        assign right_e = ent[g+1];
      end
      swrr_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid_i     (CW'(g) < count),
        .left_entry  (left_e),
        .right_entry (right_e),
        .left_lt     (left_l),
        .entry_o     (ent[g]),
        .lt_o        (lt[g]),
        .eq_o        (eq[g])
      );
    end
  endgenerate

  // Report head entry and duplicate match
  assign stat.head = ent[0];
  assign stat.dup  = |eq;

endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_receive_reorder.sv
// Top level: receive window check, reorder table sequencing and delivery.
//
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  input   | in_valid / in_ready / in_word  | segment header or timer tick
//  output  | out_valid / out_ready/out_word | data, end of stream, ack words
//  config  | cfg_valid / cfg_ready/cfg_data | receive window
//
// One input word at a time, set by the single sequencer over the cell row: it
// accepts the word, checks it (a timer tick skips the check), inserts it if it
// carries data or FIN, is new and fits, then removes head entries in order (data
// word, then FIN word or plain removal) until the head is not deliverable and
// acks if it delivered any; a failed word is dropped, one outside the window only acked.
// Reset is synchronous; the table needs no clearing. A stalled output word
// stops the sequencer until it is taken; config is always ready.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_receive_reorder #(
  parameter int REORDER_SLOTS = swrr_pkg::DEF_REORDER_SLOTS,
  parameter int HEADER_BYTES  = swrr_pkg::DEF_HEADER_BYTES
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire swrr_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire                     out_ready,
  output swrr_pkg::out_word_t     out_word,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [15:0]              cfg_data
);
  import swrr_pkg::*;

  localparam int CW = $clog2(REORDER_SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_INSERT = 6'b000100,
    S_DELIV  = 6'b001000,
    S_FIN    = 6'b010000,
    S_ACK    = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  in_word_t    item_r, item_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] la_r, la_nxt;
  logic        fin_seen_r, fin_seen_nxt;
  logic [15:0] space_r, space_nxt;
  logic        delivered_r, delivered_nxt;
  logic [15:0] win_r, win_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  chain_ctrl_t ctrl;
  chain_stat_t stat;

  logic        drop;
  logic [15:0] dlen;
  logic [31:0] lastb, lo, hi;
  logic        head_ok;
  logic        can_emit;

  swrr_chain #(.SLOTS(REORDER_SLOTS), .CW(CW)) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count_r),
    .stat  (stat)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Segment checks
  assign dlen  = item_r.segment_length - 16'(HEADER_BYTES);
  assign drop  = (item_r.received_length < item_r.segment_length) || !item_r.checksum_ok ||
                 (item_r.segment_length < 16'(HEADER_BYTES));
  assign lastb = item_r.seq_number + {16'd0, dlen} - 32'd1;
  assign lo    = la_r + 32'd1;
  assign hi    = la_r + {16'd0, win_r};

  assign head_ok  = (count_r != '0) && (stat.head.seq == lo) && (stat.head.len <= space_r);
  assign can_emit = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    count_nxt      = count_r;
    la_nxt         = la_r;
    fin_seen_nxt   = fin_seen_r;
    space_nxt      = space_r;
    delivered_nxt  = delivered_r;
    win_nxt        = win_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    ctrl.op        = OP_HOLD;
    ctrl.new_entry = '{seq: item_r.seq_number, len: dlen, fin: item_r.fin_flag};

    if (cfg_valid) begin
      win_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_word;
          space_nxt     = in_word.buffer_space;
          delivered_nxt = 1'b0;
          state_nxt     = in_word.action ? S_DELIV : S_EVAL;
        end
      end
      S_EVAL: begin
        if (drop) begin
          state_nxt = S_IDLE;
        end else if ((dlen != 16'd0) && ((lastb < lo) || (lastb > hi))) begin
          state_nxt = S_ACK;
        end else if (((dlen != 16'd0) || item_r.fin_flag) && !stat.dup &&
                     (count_r < CW'(REORDER_SLOTS))) begin
          state_nxt = S_INSERT;
        end else begin
          state_nxt = S_DELIV;
        end
      end
      S_INSERT: begin
        ctrl.op   = OP_INSERT;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DELIV;
      end
      S_DELIV: begin
        if (!head_ok) begin
          state_nxt = delivered_r ? S_ACK : S_IDLE;
        end else if (stat.head.len == 16'd0) begin
          state_nxt = S_FIN;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{kind: KIND_DATA, deliver_seq: stat.head.seq,
                            deliver_length: stat.head.len, ack_value: 32'd0,
                            advertised_window: 16'd0, last: 1'b0};
          la_nxt        = la_r + {16'd0, stat.head.len};
          space_nxt     = space_r - stat.head.len;
          delivered_nxt = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.head.fin && !fin_seen_r) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{kind: KIND_EOS, deliver_seq: lo, deliver_length: 16'd0,
                              ack_value: 32'd0, advertised_window: 16'd0, last: 1'b0};
            la_nxt        = lo;
            fin_seen_nxt  = 1'b1;
            delivered_nxt = 1'b1;
            ctrl.op       = OP_SHIFT;
            count_nxt     = count_r - CW'(1);
            state_nxt     = S_DELIV;
          end
        end else begin
          ctrl.op   = OP_SHIFT;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DELIV;
        end
      end
      S_ACK: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{kind: KIND_ACK, deliver_seq: 32'd0, deliver_length: 16'd0,
                            ack_value: lo, advertised_window: win_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      la_r        <= '0;
      fin_seen_r  <= 1'b0;
      delivered_r <= 1'b0;
      win_r       <= WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      la_r        <= la_nxt;
      fin_seen_r  <= fin_seen_nxt;
      delivered_r <= delivered_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    space_r    <= space_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
`default_nettype wire
